// ===== design/ecc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_pkg
// Types and constants shared by the elevator car controller.
// ----------------------------------------------------------------------------
package ecc_pkg;

    // Building geometry; the width of the button field follows from it
    localparam int FLOORS      = 4;
    localparam int BTN_TYPES   = 3;
    localparam int ORDER_W     = FLOORS * BTN_TYPES;
    localparam int FLOOR_W     = 2;
    localparam int TIMER_W     = 16;

    // Button type offsets within one floor group
    localparam int BTN_HALL_UP   = 0;
    localparam int BTN_HALL_DOWN = 1;
    localparam int BTN_CAB       = 2;

    localparam logic [TIMER_W-1:0] DOOR_TICKS_RESET = 16'd300;

    typedef enum logic [2:0] {
        MODE_CAL   = 3'd0,
        MODE_IDLE  = 3'd1,
        MODE_MOVE  = 3'd2,
        MODE_DOOR  = 3'd3,
        MODE_ESTOP = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // One output beat
    typedef struct packed {
        dir_t               motor_dir;
        logic [ORDER_W-1:0] button_lamps;
        logic [FLOOR_W-1:0] floor_lamp;
        logic               door_lamp;
        logic               stop_lamp;
        mode_t              mode;
    } result_t;

endpackage

// ===== design/elevator_car_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_car_controller
// Single-car elevator controller: calibration, order map, direction choice,
// floor service and door timing, one sample tick per input beat.
// ----------------------------------------------------------------------------
// Output: the result of a tick is registered into the output buffer when the
//   input beat is accepted.
// Throughput: one tick per cycle while in_stall is low; bounded by the controller state registers,
//   which are updated once per accepted beat. A two-entry output buffer lets
//   input beats keep flowing while one result waits.
// Reset: asynchronous; the car restarts in calibration with an empty order
//   map and a door time of 300 ticks.
module elevator_car_controller
    import ecc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // configuration write channel (door open time)
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TIMER_W-1:0] cfg_data,

    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               at_floor,
    input  logic [FLOOR_W-1:0] sensed_floor,
    input  logic [ORDER_W-1:0] call_buttons,
    input  logic               stop_pressed,
    input  logic               obstructed,

    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         motor_dir,
    output logic [ORDER_W-1:0] button_lamps,
    output logic [FLOOR_W-1:0] floor_lamp,
    output logic               door_lamp,
    output logic               stop_lamp,
    output logic [2:0]         mode
);

    // controller state
    logic [ORDER_W-1:0] order_reg,    order_next;
    logic [FLOOR_W-1:0] floor_reg,    floor_next;
    dir_t               dir_reg,      dir_next;
    mode_t              mode_reg,     mode_next;
    logic               cal_reg,      cal_next;
    logic [TIMER_W-1:0] timer_reg,    timer_next;
    logic [TIMER_W-1:0] door_ticks_reg;

    // output buffer
    result_t            main_reg;
    logic               main_valid_reg;
    result_t            skid_reg;
    logic               skid_valid_reg;
    result_t            result;

    logic               in_fire;
    logic               out_fire;
    logic               here;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = main_valid_reg;
    assign out_fire  = main_valid_reg && !out_stall;
    assign cfg_ready = 1'b1;

    // sensor sees a floor that exists
    assign here = at_floor && (int'(sensed_floor) < FLOORS);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_ticks_reg <= DOOR_TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            door_ticks_reg <= cfg_data;
        end
    end

    // next state of the controller for the current tick
    always_comb
    begin : next_state
        logic [ORDER_W-1:0] pressed;
        logic [ORDER_W-1:0] fmask;
        logic               door_req;
        logic               any_up;
        logic               any_dn;
        logic               keep_up;
        logic               keep_dn;
        logic               serve;
        logic               keep;
        logic [BTN_TYPES-1:0] grp;

        order_next = order_reg;
        floor_next = floor_reg;
        dir_next   = dir_reg;
        mode_next  = mode_reg;
        cal_next   = cal_reg;
        timer_next = timer_reg;

        pressed  = call_buttons;
        fmask    = ORDER_W'(7) << (BTN_TYPES * int'(sensed_floor));
        door_req = 1'b0;
        any_up   = 1'b0;
        any_dn   = 1'b0;
        keep_up  = 1'b0;
        keep_dn  = 1'b0;
        serve    = 1'b0;
        keep     = 1'b0;
        grp      = '0;

        if (mode_reg == MODE_CAL || !cal_reg)
        begin
            // calibration: wait for any floor
            mode_next = MODE_CAL;
            if (here)
            begin
                cal_next   = 1'b1;
                floor_next = sensed_floor;
                mode_next  = MODE_IDLE;
            end
        end
        else if (mode_reg == MODE_ESTOP || (stop_pressed && mode_reg != MODE_DOOR))
        begin
            // emergency stop: orders cleared while held
            order_next = '0;
            if (here)
            begin
                floor_next = sensed_floor;
            end
            if (stop_pressed)
            begin
                mode_next = MODE_ESTOP;
            end
            else if (here)
            begin
                mode_next  = MODE_DOOR;
                timer_next = door_ticks_reg;
            end
            else
            begin
                mode_next = MODE_IDLE;
            end
        end
        else
        begin
            // register calls; a call at the current floor asks for the door
            if (here)
            begin
                floor_next = sensed_floor;
                door_req   = (pressed & fmask) != '0;
                pressed    = pressed & ~fmask;
            end
            order_next = order_reg | pressed;

            // scans over the floor groups of the updated order map
            for (int g = 0; g < FLOORS; g++)
            begin
                if (g > int'(floor_next) &&
                    order_next[BTN_TYPES*g +: BTN_TYPES] != '0)
                begin
                    any_up = 1'b1;
                end
                if (g < int'(floor_next) &&
                    order_next[BTN_TYPES*g +: BTN_TYPES] != '0)
                begin
                    any_dn = 1'b1;
                end
                if (g > int'(sensed_floor) &&
                    (order_next[BTN_TYPES*g + BTN_HALL_DOWN] ||
                     order_next[BTN_TYPES*g + BTN_CAB]))
                begin
                    keep_up = 1'b1;
                end
                if (g < int'(sensed_floor) &&
                    (order_next[BTN_TYPES*g + BTN_HALL_UP] ||
                     order_next[BTN_TYPES*g + BTN_CAB]))
                begin
                    keep_dn = 1'b1;
                end
            end

            unique case (mode_reg)
                MODE_IDLE:
                begin
                    if (door_req)
                    begin
                        mode_next  = MODE_DOOR;
                        timer_next = door_ticks_reg;
                    end
                    else if (dir_reg == DIR_UP && any_up)
                    begin
                        mode_next = MODE_MOVE;
                    end
                    else if (dir_reg == DIR_DOWN && any_dn)
                    begin
                        mode_next = MODE_MOVE;
                    end
                    else if (any_up)
                    begin
                        dir_next  = DIR_UP;
                        mode_next = MODE_MOVE;
                    end
                    else if (any_dn)
                    begin
                        dir_next  = DIR_DOWN;
                        mode_next = MODE_MOVE;
                    end
                end
                MODE_MOVE:
                begin
                    grp = BTN_TYPES'(order_next >> (BTN_TYPES * int'(sensed_floor)));
                    if (door_req)
                    begin
                        order_next = order_next & ~fmask;
                        mode_next  = MODE_DOOR;
                        timer_next = door_ticks_reg;
                    end
                    else if (here && grp != '0)
                    begin
                        // stop if an order here matches the travel direction, or if no onward order keeps the car going
                        serve = (dir_reg == DIR_UP &&
                                 (grp[BTN_HALL_UP] || grp[BTN_CAB] ||
                                  (int'(sensed_floor) == FLOORS - 1 && grp[BTN_HALL_DOWN])))
                             || (dir_reg == DIR_DOWN &&
                                 (grp[BTN_HALL_DOWN] || grp[BTN_CAB] ||
                                  (sensed_floor == '0 && grp[BTN_HALL_UP])));
                        keep  = !serve &&
                                ((dir_reg == DIR_UP && keep_up) ||
                                 (dir_reg == DIR_DOWN && keep_dn));
                        if (!keep)
                        begin
                            order_next = order_next & ~fmask;
                            mode_next  = MODE_DOOR;
                            timer_next = door_ticks_reg;
                        end
                    end
                end
                MODE_DOOR:
                begin
                    // door count restarts on any hold condition
                    if (door_req || obstructed || stop_pressed)
                    begin
                        timer_next = door_ticks_reg;
                    end
                    else if (timer_reg <= TIMER_W'(1))
                    begin
                        timer_next = '0;
                        mode_next  = MODE_IDLE;
                    end
                    else
                    begin
                        timer_next = timer_reg - TIMER_W'(1);
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // outputs derived from the new state
    always_comb
    begin
        result.button_lamps = order_next;
        result.floor_lamp   = floor_next;
        result.mode         = mode_next;
        result.stop_lamp    = (mode_next == MODE_ESTOP);
        result.door_lamp    = (mode_next == MODE_DOOR) ||
                              (mode_next == MODE_ESTOP && here);
        unique case (mode_next)
            MODE_CAL:  result.motor_dir = DIR_DOWN;
            MODE_MOVE: result.motor_dir = dir_next;
            default:   result.motor_dir = DIR_STOP;
        endcase
    end

    // state registers, advanced once per input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= '0;
            floor_reg <= '0;
            dir_reg   <= DIR_STOP;
            mode_reg  <= MODE_CAL;
            cal_reg   <= 1'b0;
            timer_reg <= '0;
        end
        else if (in_fire)
        begin
            order_reg <= order_next;
            floor_reg <= floor_next;
            dir_reg   <= dir_next;
            mode_reg  <= mode_next;
            cal_reg   <= cal_next;
            timer_reg <= timer_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!main_valid_reg || out_fire)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (in_fire)
        begin
            if (!main_valid_reg || out_fire)
            begin
                main_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
    end

    assign motor_dir    = main_reg.motor_dir;
    assign button_lamps = main_reg.button_lamps;
    assign floor_lamp   = main_reg.floor_lamp;
    assign door_lamp    = main_reg.door_lamp;
    assign stop_lamp    = main_reg.stop_lamp;
    assign mode         = main_reg.mode;

endmodule

// ===== bench/car_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// car_check_pkg
// Panel scoreboard for the elevator car controller: tracks the car state one
// sensor tick at a time and checks each output beat against the oldest
// predicted panel.
// ----------------------------------------------------------------------------
package car_check_pkg;

    import ecc_pkg::*;

    class car_panel_board;

        // tracked car state
        logic [ORDER_W-1:0] orders;
        logic [FLOOR_W-1:0] floor_now;
        dir_t               heading;
        mode_t              state;
        logic               calibrated;
        logic [TIMER_W-1:0] door_count;
        logic [TIMER_W-1:0] door_ticks;
        dir_t               motor_now;

        // predicted panels, oldest first
        result_t            panel_queue[$];

        int                 errors;
        int                 ticks_logged;
        int                 panels_checked;
        int                 moving_seen;
        int                 door_seen;
        int                 estop_seen;

        function new();
            orders         = '0;
            floor_now      = '0;
            heading        = DIR_STOP;
            state          = MODE_CAL;
            calibrated     = 1'b0;
            door_count     = '0;
            door_ticks     = DOOR_TICKS_RESET;
            motor_now      = DIR_DOWN;
            errors         = 0;
            ticks_logged   = 0;
            panels_checked = 0;
            moving_seen    = 0;
            door_seen      = 0;
            estop_seen     = 0;
        endfunction

        function void set_door_ticks(logic [TIMER_W-1:0] v);
            door_ticks = v;
        endfunction

        function bit has_order(int f, int t);
            return orders[BTN_TYPES * f + t];
        endfunction

        function void open_door();
            state      = MODE_DOOR;
            door_count = door_ticks;
        endfunction

        // Advance the car by one accepted sensor tick and queue the panel it shows
        function void log_tick(logic at, logic [FLOOR_W-1:0] sf,
                               logic [ORDER_W-1:0] btn, logic stop, logic obst);
            logic [ORDER_W-1:0] pressed;
            logic [ORDER_W-1:0] here_bits;
            logic               door_req;
            logic               serve;
            logic               keep;
            logic               up_calls;
            logic               down_calls;
            int                 f;
            result_t            want;

            f         = int'(sf);
            pressed   = btn;
            here_bits = ORDER_W'(7) << (BTN_TYPES * f);
            door_req  = 1'b0;
            ticks_logged++;

            if (state == MODE_CAL || !calibrated)
            begin
                // drive down until any floor is seen; buttons and stop ignored
                state = MODE_CAL;
                if (at)
                begin
                    calibrated = 1'b1;
                    floor_now  = sf;
                    state      = MODE_IDLE;
                end
            end
            else if (state == MODE_ESTOP || (stop && state != MODE_DOOR))
            begin
                // emergency stop: orders wiped while held
                orders = '0;
                if (at)
                    floor_now = sf;
                if (stop)
                    state = MODE_ESTOP;
                else if (at)
                    open_door();
                else
                    state = MODE_IDLE;
            end
            else
            begin
                // calls at the current floor open the door instead of storing
                if (at)
                begin
                    floor_now = sf;
                    door_req  = (pressed & here_bits) != '0;
                    pressed   = pressed & ~here_bits;
                end
                orders = orders | pressed;

                if (state == MODE_IDLE)
                begin
                    if (door_req)
                        open_door();
                    else
                    begin
                        // keep the old heading while calls remain that way
                        up_calls   = (orders >> (BTN_TYPES * (int'(floor_now) + 1))) != '0;
                        down_calls = (orders & ((ORDER_W'(1) << (BTN_TYPES * int'(floor_now)))
                                     - ORDER_W'(1))) != '0;
                        if (heading == DIR_UP && up_calls)
                            state = MODE_MOVE;
                        else if (heading == DIR_DOWN && down_calls)
                            state = MODE_MOVE;
                        else if (up_calls)
                        begin
                            heading = DIR_UP;
                            state   = MODE_MOVE;
                        end
                        else if (down_calls)
                        begin
                            heading = DIR_DOWN;
                            state   = MODE_MOVE;
                        end
                    end
                end
                else if (state == MODE_MOVE)
                begin
                    if (door_req)
                    begin
                        orders = orders & ~here_bits;
                        open_door();
                    end
                    else if (at && (orders & here_bits) != '0)
                    begin
                        // stop for calls our way or if none lie onward; ends take either
                        serve = (heading == DIR_UP &&
                                    (has_order(f, BTN_HALL_UP) || has_order(f, BTN_CAB) ||
                                     (f == FLOORS - 1 && has_order(f, BTN_HALL_DOWN)))) ||
                                (heading == DIR_DOWN &&
                                    (has_order(f, BTN_HALL_DOWN) || has_order(f, BTN_CAB) ||
                                     (f == 0 && has_order(f, BTN_HALL_UP))));
                        keep = 1'b0;
                        if (!serve && heading == DIR_UP)
                            for (int g = f + 1; g < FLOORS; g++)
                                if (has_order(g, BTN_HALL_DOWN) || has_order(g, BTN_CAB))
                                    keep = 1'b1;
                        if (!serve && heading == DIR_DOWN)
                            for (int g = 0; g < f; g++)
                                if (has_order(g, BTN_HALL_UP) || has_order(g, BTN_CAB))
                                    keep = 1'b1;
                        if (!keep)
                        begin
                            orders = orders & ~here_bits;
                            open_door();
                        end
                    end
                end
                else
                begin
                    // door open: restart on call here, obstruction or stop
                    if (door_req || obst || stop)
                        door_count = door_ticks;
                    else if (door_count <= 1)
                    begin
                        door_count = '0;
                        state      = MODE_IDLE;
                    end
                    else
                        door_count = door_count - 1'b1;
                end
            end

            // panel after the tick
            if (state == MODE_CAL)
                motor_now = DIR_DOWN;
            else if (state == MODE_MOVE)
                motor_now = heading;
            else
                motor_now = DIR_STOP;

            want.motor_dir    = motor_now;
            want.button_lamps = orders;
            want.floor_lamp   = floor_now;
            want.door_lamp    = (state == MODE_DOOR) || (state == MODE_ESTOP && at);
            want.stop_lamp    = (state == MODE_ESTOP);
            want.mode         = state;
            panel_queue.push_back(want);

            if (state == MODE_MOVE)
                moving_seen++;
            if (state == MODE_DOOR)
                door_seen++;
            if (state == MODE_ESTOP)
                estop_seen++;
        endfunction

        // Compare one output beat with the oldest predicted panel
        function void check_panel(result_t got);
            result_t want;

            if (panel_queue.size() == 0)
            begin
                $error("output beat with no tick pending: mode %0d", got.mode);
                errors++;
                return;
            end
            want = panel_queue.pop_front();
            panels_checked++;

            if (got.motor_dir !== want.motor_dir)
            begin
                $error("motor_dir: expected %0d, got %0d", want.motor_dir, got.motor_dir);
                errors++;
            end
            if (got.button_lamps !== want.button_lamps)
            begin
                $error("button_lamps: expected %03h, got %03h",
                       want.button_lamps, got.button_lamps);
                errors++;
            end
            if (got.floor_lamp !== want.floor_lamp)
            begin
                $error("floor_lamp: expected %0d, got %0d", want.floor_lamp, got.floor_lamp);
                errors++;
            end
            if (got.door_lamp !== want.door_lamp)
            begin
                $error("door_lamp: expected %0b, got %0b", want.door_lamp, got.door_lamp);
                errors++;
            end
            if (got.stop_lamp !== want.stop_lamp)
            begin
                $error("stop_lamp: expected %0b, got %0b", want.stop_lamp, got.stop_lamp);
                errors++;
            end
            if (got.mode !== want.mode)
            begin
                $error("mode: expected %0d, got %0d", want.mode, got.mode);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the elevator car controller. Drives sensor ticks from a simple
// shaft model that follows the predicted motor, plus directed cases and noise,
// under random idling on both sides and one long output hold-off. Every output
// beat is checked field by field against the panel scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    import ecc_pkg::*;
    import car_check_pkg::*;

    localparam int QUIET_LIMIT    = 2000;   // cycles with no beat moving
    localparam int SQUEEZE_CYCLES = 120;    // long output hold-off

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [TIMER_W-1:0] cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               at_floor     = 1'b0;
    logic [FLOOR_W-1:0] sensed_floor = '0;
    logic [ORDER_W-1:0] call_buttons = '0;
    logic               stop_pressed = 1'b0;
    logic               obstructed   = 1'b0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [1:0]         motor_dir;
    logic [ORDER_W-1:0] button_lamps;
    logic [FLOOR_W-1:0] floor_lamp;
    logic               door_lamp;
    logic               stop_lamp;
    logic [2:0]         mode;

    car_panel_board panel;
    result_t        seen;
    int             quiet_cycles   = 0;
    int             car_pos        = 0;    // even: at floor car_pos/2, odd: between
    int             stop_hold      = 0;
    int             settings_used  = 0;
    bit             squeeze        = 1'b0;
    bit             calm           = 1'b0;

    elevator_car_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .at_floor     (at_floor),
        .sensed_floor (sensed_floor),
        .call_buttons (call_buttons),
        .stop_pressed (stop_pressed),
        .obstructed   (obstructed),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .motor_dir    (motor_dir),
        .button_lamps (button_lamps),
        .floor_lamp   (floor_lamp),
        .door_lamp    (door_lamp),
        .stop_lamp    (stop_lamp),
        .mode         (mode)
    );

    always #5 clk = ~clk;

    function automatic logic [ORDER_W-1:0] call_bit(int f, int t);
        return ORDER_W'(1) << (BTN_TYPES * f + t);
    endfunction

    // One tick beat: hold until accepted, then maybe idle a burst
    task automatic send_tick(input logic at, input logic [FLOOR_W-1:0] sf,
                             input logic [ORDER_W-1:0] btn, input logic stop,
                             input logic obst);
        at_floor     <= at;
        sensed_floor <= sf;
        call_buttons <= btn;
        stop_pressed <= stop;
        obstructed   <= obst;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        panel.log_tick(at, sf, btn, stop, obst);
        if (!calm && !squeeze && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Shaft model following the predicted motor, with presses, stops and noise
    task automatic random_tick();
        logic               a;
        logic [FLOOR_W-1:0] sf;
        logic [ORDER_W-1:0] b;
        logic               s;
        logic               o;
        bit                 long_door;
        int                 roll;

        // keep restarts rare while a long door time runs, so the door can close
        long_door = (panel.state == MODE_DOOR) && (panel.door_ticks >= 16);
        if (!long_door && $urandom_range(0, 99) < 8)
        begin
            a  = 1'($urandom_range(0, 1));
            sf = FLOOR_W'($urandom);
            b  = ORDER_W'($urandom);
            s  = 1'($urandom_range(0, 1));
            o  = 1'($urandom_range(0, 1));
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                car_pos = $urandom_range(0, 2 * FLOORS - 2);
            else if (panel.motor_now == DIR_UP && car_pos < 2 * FLOORS - 2 &&
                     $urandom_range(0, 2) == 0)
                car_pos++;
            else if (panel.motor_now == DIR_DOWN && car_pos > 0 && $urandom_range(0, 2) == 0)
                car_pos--;

            if (stop_hold > 0)
                stop_hold--;
            else if (!long_door && $urandom_range(0, 99) < 2)
                stop_hold = $urandom_range(1, 6);

            a    = (car_pos % 2) == 0;
            sf   = a ? FLOOR_W'(car_pos / 2) : FLOOR_W'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < (long_door ? 1 : 14))
                b = ORDER_W'(1) << $urandom_range(0, ORDER_W - 1);
            else if (!long_door && roll < 17)
                b = ORDER_W'($urandom);
            else
                b = '0;
            s = stop_hold > 0;
            o = panel.state == MODE_DOOR && !long_door && $urandom_range(0, 15) == 0;
        end
        send_tick(a, sf, b, s, o);
    endtask

    task automatic run_random(input int n, input int squeeze_at);
        for (int i = 0; i < n; i++)
        begin
            if (i == squeeze_at)
                squeeze = 1'b1;
            random_tick();
        end
    endtask

    task automatic write_door_ticks(input logic [TIMER_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        panel.set_door_ticks(v);
        settings_used++;
    endtask

    // Drain every pending panel, let the pipe settle, then rewrite the door time
    task automatic settle_and_write(input logic [TIMER_W-1:0] v);
        in_valid <= 1'b0;
        while (panel.panel_queue.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        write_door_ticks(v);
    endtask

    // Output side: random stall bursts, one long hold-off, none at the end
    initial
    begin
        forever
        begin
            if (squeeze)
            begin
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze = 1'b0;
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
                if ($urandom_range(0, 3) != 0)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 18)) @(posedge clk);
                end
            end
        end
    end

    // Output beat check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen.motor_dir    = dir_t'(motor_dir);
                seen.button_lamps = button_lamps;
                seen.floor_lamp   = floor_lamp;
                seen.door_lamp    = door_lamp;
                seen.stop_lamp    = stop_lamp;
                seen.mode         = mode_t'(mode);
                panel.check_panel(seen);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        panel = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero door time behaves as one tick
        write_door_ticks('0);

        // directed: calibration, door, stop, direction and serve rules
        send_tick(1'b0, 2'd1, '1, 1'b1, 1'b1);      // ignored while calibrating
        send_tick(1'b1, 2'd0, '1, 1'b0, 1'b0);      // calibrates at floor 0
        send_tick(1'b1, 2'd0, call_bit(0, BTN_HALL_UP), 1'b0, 1'b0);  // call here
        send_tick(1'b1, 2'd0, '0, 1'b1, 1'b0);      // stop restarts door
        send_tick(1'b1, 2'd0, '0, 1'b0, 1'b1);      // obstruction restarts door
        send_tick(1'b1, 2'd0, '0, 1'b0, 1'b0);      // door closes
        send_tick(1'b1, 2'd0, call_bit(3, BTN_CAB), 1'b1, 1'b0);  // stop while idle
        send_tick(1'b0, 2'd2, '0, 1'b1, 1'b0);      // held between floors
        send_tick(1'b1, 2'd0, '0, 1'b0, 1'b0);      // release at floor
        send_tick(1'b1, 2'd0, '0, 1'b0, 1'b0);
        send_tick(1'b1, 2'd0, call_bit(3, BTN_CAB) | call_bit(2, BTN_HALL_DOWN),
                  1'b0, 1'b0);
        send_tick(1'b1, 2'd1, '0, 1'b0, 1'b0);      // pass empty floor
        send_tick(1'b1, 2'd2, '0, 1'b0, 1'b0);      // hall down skipped going up
        send_tick(1'b1, 2'd3, '0, 1'b0, 1'b0);      // cab served at top
        send_tick(1'b1, 2'd3, '0, 1'b0, 1'b0);
        send_tick(1'b1, 2'd3, '0, 1'b0, 1'b0);      // turns down
        send_tick(1'b1, 2'd2, '0, 1'b0, 1'b0);      // hall down served
        send_tick(1'b1, 2'd2, '0, 1'b0, 1'b0);
        send_tick(1'b1, 2'd2, call_bit(3, BTN_HALL_DOWN), 1'b0, 1'b0);
        send_tick(1'b1, 2'd3, '0, 1'b0, 1'b0);      // hall down taken at top
        send_tick(1'b1, 2'd3, '0, 1'b0, 1'b0);
        send_tick(1'b1, 2'd3, call_bit(0, BTN_HALL_UP) | call_bit(1, BTN_HALL_UP),
                  1'b0, 1'b0);
        send_tick(1'b1, 2'd1, call_bit(1, BTN_CAB), 1'b0, 1'b0);  // call here while moving
        send_tick(1'b1, 2'd1, '0, 1'b0, 1'b0);
        send_tick(1'b1, 2'd1, '0, 1'b0, 1'b0);
        send_tick(1'b1, 2'd0, '0, 1'b0, 1'b0);      // hall up taken at bottom

        // random phases over several door times
        car_pos = 0;
        settle_and_write(16'd1);
        run_random(300, -1);
        settle_and_write(DOOR_TICKS_RESET);
        run_random(300, 100);
        settle_and_write(16'hFFFF);
        run_random(100, -1);
        settle_and_write(TIMER_W'($urandom_range(2, 6)));
        run_random(300, -1);
        calm = 1'b1;
        settle_and_write(TIMER_W'($urandom_range(1, 4)));
        run_random(250, -1);

        // drain and finish
        in_valid <= 1'b0;
        while (panel.panel_queue.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Covered %0d sensor ticks under %0d door-time settings (zero and max).",
                 panel.ticks_logged, settings_used);
        $display("Checked %0d panels: %0d moving, %0d door open, %0d emergency stop.",
                 panel.panels_checked, panel.moving_seen, panel.door_seen, panel.estop_seen);
        if (panel.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
